/* src/sdcrt_pkg.sv */
package sdcrt_pkg;

	localparam int unsigned LIMIT_W = 16;
	localparam int unsigned TOK_W   = 12;
	localparam int unsigned ALIGN_W = 4;
	localparam int unsigned RXC_W   = 20;
	localparam int unsigned FLEN_W  = 16;
	localparam int unsigned ADDR_W  = 17;

	localparam logic [ADDR_W-1:0] FIFO_END      = 17'h1f800;
	localparam logic [TOK_W-1:0]  START_CREDITS = 12'd10;
	localparam logic [TOK_W-1:0]  DEFAULT_TOKEN = 12'd512;
	localparam logic [ADDR_W-1:0] BLOCK_MASK    = 17'd511;

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_RX    = 2'd1;
	localparam logic [1:0] KIND_TX    = 2'd2;
	localparam logic [1:0] KIND_STOP  = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_EMPTY    = 3'd1;
	localparam logic [2:0] ST_TOO_BIG  = 3'd2;
	localparam logic [2:0] ST_BUSY     = 3'd3;
	localparam logic [2:0] ST_INVALID  = 3'd4;
	localparam logic [2:0] ST_INACTIVE = 3'd5;

	localparam logic [1:0] CFG_RX_LIMIT     = 2'd0;
	localparam logic [1:0] CFG_CREDIT_BYTES = 2'd1;
	localparam logic [1:0] CFG_ALIGN_LOG2   = 2'd2;

	localparam logic [LIMIT_W-1:0] RST_RX_LIMIT     = 16'd1600;
	localparam logic [TOK_W-1:0]   RST_CREDIT_BYTES = 12'd512;
	localparam logic [ALIGN_W-1:0] RST_ALIGN_LOG2   = 4'd2;

endpackage

/* src/sdcrt_div.sv */
module sdcrt_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [sdcrt_pkg::FLEN_W-1:0]    dividend,
	input  logic [sdcrt_pkg::TOK_W-1:0]     divisor,
	output logic                            done,
	output logic [sdcrt_pkg::FLEN_W-1:0]    quotient
);

	localparam int unsigned CNT_W = $clog2(sdcrt_pkg::FLEN_W);

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [sdcrt_pkg::TOK_W-1:0]   dsr_q;
	logic [sdcrt_pkg::TOK_W-1:0]   rem_q;
	logic [sdcrt_pkg::FLEN_W-1:0]  quo_q;
	logic [sdcrt_pkg::TOK_W:0]     trial;
	logic [sdcrt_pkg::TOK_W:0]     diff;
	logic                          fits;

	// One quotient bit per cycle: the dividend shifts out of the top of quo_q
	// while the quotient bits shift in at the bottom.
	assign trial = {rem_q, quo_q[sdcrt_pkg::FLEN_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(sdcrt_pkg::FLEN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[sdcrt_pkg::TOK_W-1:0]
			              : trial[sdcrt_pkg::TOK_W-1:0];
			quo_q <= {quo_q[sdcrt_pkg::FLEN_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* src/sdio_rx_tx_credit_tracker.sv */
// Host-side byte and credit accounting for a packet link.
// Input channel (in_valid/in_ready) carries one event: start, receive poll,
// transmit try or stop, together with the peer's counters and frame length.
// Output channel (out_valid/out_ready) returns exactly one result for each
// event. The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data)
// writes rx_limit, credit_bytes and align_log2; it is always ready and should
// be used only while no event is in flight.
// One event is handled at a time. Start, receive and stop events pass through
// S_DONE into the output register; a transmit try first waits in S_DIV for the
// bit-serial divider, which works out the credit count one quotient bit per
// cycle for all 16 bits of the quotient, and then passes through S_DONE. A new
// event is accepted in the cycle after a result has been loaded into the output
// register, so no event is taken while an earlier one is still being worked on.
// If the receiver stalls, the finished result waits in the output register
// and a following event is accepted and worked on, but its result is held
// until the output register is freed.
// Reset clears the counters and flags and restores the register defaults
// (rx_limit 1600, credit_bytes 512, align_log2 2).
module sdio_rx_tx_credit_tracker (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [19:0] rx_counter,
	input  logic [31:0] token_word,
	input  logic [15:0] frame_length,
	input  logic        transfer_ok,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic        counter_was_reset,
	output logic [15:0] rx_bytes,
	output logic [16:0] rx_read_length,
	output logic [16:0] rx_address,
	output logic [11:0] credits_free,
	output logic [15:0] credits_needed,
	output logic [16:0] tx_write_length,
	output logic [16:0] tx_address
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0] state_q;

	logic [sdcrt_pkg::LIMIT_W-1:0] rx_limit_q;
	logic [sdcrt_pkg::TOK_W-1:0]   credit_bytes_q;
	logic [sdcrt_pkg::ALIGN_W-1:0] align_log2_q;

	logic [sdcrt_pkg::RXC_W-1:0] rx_consumed_q;
	logic [sdcrt_pkg::TOK_W-1:0] tx_sent_q;
	logic                        rx_seeded_q;
	logic                        link_active_q;

	logic [1:0]                   kind_q;
	logic [sdcrt_pkg::RXC_W-1:0]  rxc_q;
	logic [sdcrt_pkg::TOK_W-1:0]  peer_tok_q;
	logic [sdcrt_pkg::FLEN_W-1:0] flen_q;
	logic                         ok_q;

	logic                         in_fire;
	logic                         finish;
	logic                         div_start;
	logic                         div_done;
	logic [sdcrt_pkg::FLEN_W-1:0] div_quo;
	logic [sdcrt_pkg::TOK_W-1:0]  ts_eff;

	logic                         out_valid_q;
	logic [2:0]                   status_q;
	logic                         cwr_q;
	logic [15:0]                  rx_bytes_q;
	logic [16:0]                  rx_rlen_q;
	logic [16:0]                  rx_addr_q;
	logic [11:0]                  cfree_q;
	logic [15:0]                  cneed_q;
	logic [16:0]                  tx_wlen_q;
	logic [16:0]                  tx_addr_q;

	// Result and next state, worked out from the held event in S_DONE.
	logic [2:0]                   r_status;
	logic                         r_cwr;
	logic [15:0]                  r_rx_bytes;
	logic [16:0]                  r_rx_rlen;
	logic [16:0]                  r_rx_addr;
	logic [11:0]                  r_cfree;
	logic [15:0]                  r_cneed;
	logic [16:0]                  r_tx_wlen;
	logic [16:0]                  r_tx_addr;
	logic [sdcrt_pkg::RXC_W-1:0]  nx_consumed;
	logic [sdcrt_pkg::TOK_W-1:0]  nx_sent;
	logic                         nx_seeded;
	logic                         nx_active;

	logic [sdcrt_pkg::RXC_W-1:0]  avail;
	logic                         restart;
	logic [sdcrt_pkg::RXC_W-1:0]  eff;
	logic [16:0]                  amask;
	logic [16:0]                  rx_sum;
	logic [16:0]                  tx_sum;
	logic [sdcrt_pkg::TOK_W-1:0]  freec;
	logic [15:0]                  needed;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign finish    = (state_q == S_DONE) && (!out_valid_q || out_ready);

	assign div_start = in_fire && (kind == sdcrt_pkg::KIND_TX);
	assign ts_eff = (credit_bytes_q == '0) ? sdcrt_pkg::DEFAULT_TOKEN : credit_bytes_q;

	// ceil(n / d) for n >= 1 is floor((n - 1) / d) + 1.
	sdcrt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (frame_length - 16'd1),
		.divisor  (ts_eff),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_limit_q     <= sdcrt_pkg::RST_RX_LIMIT;
			credit_bytes_q <= sdcrt_pkg::RST_CREDIT_BYTES;
			align_log2_q   <= sdcrt_pkg::RST_ALIGN_LOG2;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sdcrt_pkg::CFG_RX_LIMIT:     rx_limit_q <= cfg_data;
				sdcrt_pkg::CFG_CREDIT_BYTES:
					credit_bytes_q <= cfg_data[sdcrt_pkg::TOK_W-1:0];
				sdcrt_pkg::CFG_ALIGN_LOG2:
					align_log2_q <= cfg_data[sdcrt_pkg::ALIGN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire)
						state_q <= (kind == sdcrt_pkg::KIND_TX) ? S_DIV : S_DONE;
				end
				S_DIV: begin
					if (div_done)
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (finish)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q     <= kind;
			rxc_q      <= rx_counter;
			peer_tok_q <= token_word[27:16];
			flen_q     <= frame_length;
			ok_q       <= transfer_ok;
		end
	end

	always_comb begin
		avail   = rxc_q - rx_consumed_q;
		restart = (avail > {4'd0, rx_limit_q}) && (rxc_q <= {4'd0, rx_limit_q});
		eff     = restart ? rxc_q : avail;
		amask   = 17'((18'd1 << align_log2_q) - 18'd1);
		rx_sum  = {1'b0, eff[15:0]} + amask;
		tx_sum  = {1'b0, flen_q} + sdcrt_pkg::BLOCK_MASK;
		freec   = peer_tok_q - tx_sent_q;
		needed  = div_quo + 16'd1;

		r_status    = sdcrt_pkg::ST_OK;
		r_cwr       = 1'b0;
		r_rx_bytes  = '0;
		r_rx_rlen   = '0;
		r_rx_addr   = '0;
		r_cfree     = '0;
		r_cneed     = '0;
		r_tx_wlen   = '0;
		r_tx_addr   = '0;
		nx_consumed = rx_consumed_q;
		nx_sent     = tx_sent_q;
		nx_seeded   = rx_seeded_q;
		nx_active   = link_active_q;

		case (kind_q)
			sdcrt_pkg::KIND_START: begin
				if (!ok_q) begin
					r_status = sdcrt_pkg::ST_INVALID;
				end else begin
					if (!rx_seeded_q) begin
						nx_consumed = (rxc_q <= {4'd0, rx_limit_q}) ? '0 : rxc_q;
						nx_seeded   = 1'b1;
					end
					nx_sent   = (peer_tok_q >= sdcrt_pkg::START_CREDITS)
					          ? peer_tok_q - sdcrt_pkg::START_CREDITS : '0;
					nx_active = 1'b1;
				end
			end
			sdcrt_pkg::KIND_RX: begin
				if (!link_active_q) begin
					r_status = sdcrt_pkg::ST_INACTIVE;
				end else if (avail == '0) begin
					r_status = sdcrt_pkg::ST_EMPTY;
				end else begin
					// A restarted peer counter drops the consumed count even if
					// this transaction later fails.
					if (restart) begin
						r_cwr       = 1'b1;
						nx_consumed = '0;
					end
					if (eff == '0) begin
						r_status = sdcrt_pkg::ST_EMPTY;
					end else if (eff > {4'd0, rx_limit_q}) begin
						r_status = sdcrt_pkg::ST_TOO_BIG;
					end else begin
						r_rx_bytes = eff[15:0];
						r_rx_rlen  = rx_sum & ~amask;
						r_rx_addr  = sdcrt_pkg::FIFO_END - {1'b0, eff[15:0]};
						if (ok_q)
							nx_consumed = (restart ? '0 : rx_consumed_q) + eff;
						else
							r_status = sdcrt_pkg::ST_INVALID;
					end
				end
			end
			sdcrt_pkg::KIND_TX: begin
				if (!link_active_q) begin
					r_status = sdcrt_pkg::ST_INACTIVE;
				end else if (flen_q == '0 || flen_q > rx_limit_q) begin
					r_status = sdcrt_pkg::ST_INVALID;
				end else begin
					r_cfree = freec;
					r_cneed = needed;
					if ({4'd0, freec} < needed) begin
						r_status = sdcrt_pkg::ST_BUSY;
					end else begin
						r_tx_wlen = tx_sum & ~sdcrt_pkg::BLOCK_MASK;
						r_tx_addr = sdcrt_pkg::FIFO_END - r_tx_wlen;
						if (ok_q)
							nx_sent = tx_sent_q + needed[sdcrt_pkg::TOK_W-1:0];
						else
							r_status = sdcrt_pkg::ST_INVALID;
					end
				end
			end
			default: begin
				nx_active = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_consumed_q <= '0;
			tx_sent_q     <= '0;
			rx_seeded_q   <= 1'b0;
			link_active_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (finish) begin
				rx_consumed_q <= nx_consumed;
				tx_sent_q     <= nx_sent;
				rx_seeded_q   <= nx_seeded;
				link_active_q <= nx_active;
				out_valid_q   <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			status_q   <= r_status;
			cwr_q      <= r_cwr;
			rx_bytes_q <= r_rx_bytes;
			rx_rlen_q  <= r_rx_rlen;
			rx_addr_q  <= r_rx_addr;
			cfree_q    <= r_cfree;
			cneed_q    <= r_cneed;
			tx_wlen_q  <= r_tx_wlen;
			tx_addr_q  <= r_tx_addr;
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = status_q;
	assign counter_was_reset = cwr_q;
	assign rx_bytes          = rx_bytes_q;
	assign rx_read_length    = rx_rlen_q;
	assign rx_address        = rx_addr_q;
	assign credits_free      = cfree_q;
	assign credits_needed    = cneed_q;
	assign tx_write_length   = tx_wlen_q;
	assign tx_address        = tx_addr_q;

endmodule
